// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/kfc_pkg.sv =====
// types, key codes and sizes shared by the calculator rtl
package kfc_pkg;

  localparam int MAX_DIGITS_DEF = 8;
  localparam int KEY_W          = 8;
  localparam int OPND_W         = 27;
  localparam int CNT_W          = 4;
  localparam int RES_W          = 61;
  localparam int SUM_W          = OPND_W + 2;
  localparam int DIV_W          = 34;
  localparam int HUNDRED        = 100;
  localparam int SCALE_STEPS    = 7;
  localparam int MUL_STEPS      = OPND_W;
  localparam int STEP_W         = 6;

  localparam logic [KEY_W-1:0] KEY_0     = 8'h30;
  localparam logic [KEY_W-1:0] KEY_9     = 8'h39;
  localparam logic [KEY_W-1:0] KEY_PLUS  = 8'h2B;
  localparam logic [KEY_W-1:0] KEY_MINUS = 8'h2D;
  localparam logic [KEY_W-1:0] KEY_TIMES = 8'h2A;
  localparam logic [KEY_W-1:0] KEY_SLASH = 8'h2F;
  localparam logic [KEY_W-1:0] KEY_EQ    = 8'h3D;
  localparam logic [KEY_W-1:0] KEY_CLR   = 8'h43;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } kfc_op_t;

  typedef enum logic [2:0] {
    EV_DIGIT    = 3'd0,
    EV_OPERATOR = 3'd1,
    EV_RESULT   = 3'd2,
    EV_CLEARED  = 3'd3,
    EV_IGNORED  = 3'd4
  } kfc_event_t;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_SCALE,
    ALU_MUL,
    ALU_DIV,
    ALU_DONE
  } kfc_alu_state_t;

  typedef struct packed {
    logic    start;
    kfc_op_t op;
  } kfc_alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } kfc_alu_sts_t;

endpackage

// ===== rtl/kfc_serial_alu.sv =====
// bit-serial scale, multiply and restoring divide unit for the '=' key
module kfc_serial_alu (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kfc_pkg::kfc_alu_req_t           req,
  input  logic signed [kfc_pkg::SUM_W-1:0] x_val,
  input  logic [kfc_pkg::OPND_W-1:0]      y_val,
  output kfc_pkg::kfc_alu_sts_t           sts,
  output logic [kfc_pkg::RES_W-1:0]       result
);

  localparam int RW = kfc_pkg::RES_W;
  localparam int OW = kfc_pkg::OPND_W;
  localparam int DW = kfc_pkg::DIV_W;
  localparam int SW = kfc_pkg::STEP_W;

  kfc_pkg::kfc_alu_state_t state_r, state_nxt;
  kfc_pkg::kfc_op_t        op_r;

  logic [RW-1:0] acc_r;
  logic [RW-1:0] mcand_r;
  logic [OW-1:0] mult_r;
  logic [OW-1:0] y_r;
  logic [OW-1:0] rem_r;
  logic [SW-1:0] cnt_r;

  logic [RW-1:0] add_sum;
  logic [OW:0]   r_sh;
  logic [OW:0]   r_diff;
  logic          r_ge;
  logic          last_step;

  // one multiplier bit per cycle
  assign add_sum   = acc_r + (mult_r[0] ? mcand_r : '0);
  // one quotient bit per cycle
  assign r_sh      = {rem_r, acc_r[DW-1]};
  assign r_diff    = r_sh - {1'b0, y_r};
  assign r_ge      = (r_sh >= {1'b0, y_r});
  assign last_step = (cnt_r == SW'(1));
  assign result    = acc_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kfc_pkg::ALU_IDLE: begin
        if (req.start) state_nxt = kfc_pkg::ALU_SCALE;
      end
      kfc_pkg::ALU_SCALE: begin
        if (last_step) begin
          if (op_r == kfc_pkg::OP_MUL) state_nxt = kfc_pkg::ALU_MUL;
          else if (op_r == kfc_pkg::OP_DIV && y_r != '0) state_nxt = kfc_pkg::ALU_DIV;
          else state_nxt = kfc_pkg::ALU_DONE;
        end
      end
      kfc_pkg::ALU_MUL: begin
        if (last_step) state_nxt = kfc_pkg::ALU_DONE;
      end
      kfc_pkg::ALU_DIV: begin
        if (last_step) state_nxt = kfc_pkg::ALU_DONE;
      end
      kfc_pkg::ALU_DONE: begin
        state_nxt = kfc_pkg::ALU_IDLE;
      end
      default: state_nxt = kfc_pkg::ALU_IDLE;
    endcase
  end

  always_comb begin
    sts.busy = (state_r != kfc_pkg::ALU_IDLE);
    sts.done = (state_r == kfc_pkg::ALU_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kfc_pkg::ALU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      kfc_pkg::ALU_IDLE: begin
        if (req.start) begin
          mcand_r <= {{(RW-kfc_pkg::SUM_W){x_val[kfc_pkg::SUM_W-1]}}, x_val};
          mult_r  <= OW'(kfc_pkg::HUNDRED);
          y_r     <= y_val;
          op_r    <= req.op;
          acc_r   <= '0;
          cnt_r   <= SW'(kfc_pkg::SCALE_STEPS);
        end
      end
      kfc_pkg::ALU_SCALE, kfc_pkg::ALU_MUL: begin
        if (state_r == kfc_pkg::ALU_SCALE && last_step && op_r == kfc_pkg::OP_MUL) begin
          // scaled first operand feeds the second pass
          mcand_r <= add_sum;
          mult_r  <= y_r;
          acc_r   <= '0;
          cnt_r   <= SW'(kfc_pkg::MUL_STEPS);
        end else if (state_r == kfc_pkg::ALU_SCALE && last_step &&
                     op_r == kfc_pkg::OP_DIV) begin
          // scaled first operand becomes the dividend
          acc_r <= (y_r == '0) ? '0 : add_sum;
          rem_r <= '0;
          cnt_r <= SW'(DW);
        end else begin
          acc_r   <= add_sum;
          mcand_r <= {mcand_r[RW-2:0], 1'b0};
          mult_r  <= {1'b0, mult_r[OW-1:1]};
          cnt_r   <= cnt_r - SW'(1);
        end
      end
      kfc_pkg::ALU_DIV: begin
        acc_r <= {acc_r[RW-1:DW], acc_r[DW-2:0], r_ge};
        rem_r <= r_ge ? r_diff[OW-1:0] : r_sh[OW-1:0];
        cnt_r <= cnt_r - SW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/keypad_four_function_calculator_top.sv =====
// keypad four-function calculator: key decode, operand entry and result output
// digit, operator, clear, ignored keys and '=' with no operator are answered on the next cycle
// '=' with an operator is answered when the bit-serial unit finishes: 7 scale steps, then
//   27 multiply or 34 divide steps (add, subtract and divide by zero need only the scale steps)
// one transaction at a time: a new key is taken once the unit is free and the output slot drains
// reset (rst_n low, synchronous): operands, counts, operator and last result read as zero
`include "assert_macros.svh"

module keypad_four_function_calculator_top #(
  parameter int MAX_DIGITS = kfc_pkg::MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [kfc_pkg::KEY_W-1:0]           in_key_code,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_event_kind,
  output logic signed [kfc_pkg::RES_W-1:0]    out_result_hundredths
);

  localparam int OW = kfc_pkg::OPND_W;
  localparam int CW = kfc_pkg::CNT_W;
  localparam int SW = kfc_pkg::SUM_W;

  // operand entry state
  logic [OW-1:0]    first_op_r, first_op_nxt;
  logic [OW-1:0]    second_op_r, second_op_nxt;
  logic [CW-1:0]    first_cnt_r, first_cnt_nxt;
  logic [CW-1:0]    second_cnt_r, second_cnt_nxt;
  kfc_pkg::kfc_op_t op_r, op_nxt;
  logic             second_r, second_nxt;
  logic [kfc_pkg::RES_W-1:0] last_result_r, last_result_nxt;

  // output slot
  logic                 out_valid_r, out_valid_nxt;
  kfc_pkg::kfc_event_t  out_kind_r, out_kind_nxt;

  logic                  in_accept;
  logic [3:0]            digit;
  logic [OW-1:0]         cur_op;
  logic [OW-1:0]         cur_times10;
  logic signed [SW-1:0]  alu_x;
  logic [kfc_pkg::RES_W-1:0] alu_result;
  kfc_pkg::kfc_alu_req_t alu_req;
  kfc_pkg::kfc_alu_sts_t alu_sts;

  // a key waits while the serial unit runs or while the previous transaction is held
  assign in_stall  = alu_sts.busy || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign digit       = 4'(in_key_code - kfc_pkg::KEY_0);
  assign cur_op      = second_r ? second_op_r : first_op_r;
  // times ten as two shifted copies
  assign cur_times10 = OW'({cur_op, 3'b000} + {cur_op, 1'b0}) + OW'(digit);

  // add and subtract fold into one signed operand, scaled by 100 in the unit
  always_comb begin
    case (op_r)
      kfc_pkg::OP_ADD: alu_x = SW'({2'b00, first_op_r}) + SW'({2'b00, second_op_r});
      kfc_pkg::OP_SUB: alu_x = SW'({2'b00, first_op_r}) - SW'({2'b00, second_op_r});
      default:         alu_x = SW'({2'b00, first_op_r});
    endcase
  end

  always_comb begin
    first_op_nxt    = first_op_r;
    second_op_nxt   = second_op_r;
    first_cnt_nxt   = first_cnt_r;
    second_cnt_nxt  = second_cnt_r;
    op_nxt          = op_r;
    second_nxt      = second_r;
    last_result_nxt = last_result_r;
    out_kind_nxt    = out_kind_r;
    out_valid_nxt   = out_valid_r && out_stall;
    alu_req.start   = 1'b0;
    alu_req.op      = op_r;

    if (alu_sts.done) begin
      // unit finished: the output slot is free by construction
      last_result_nxt = alu_result;
      out_kind_nxt    = kfc_pkg::EV_RESULT;
      out_valid_nxt   = 1'b1;
    end

    if (in_accept) begin
      out_kind_nxt  = kfc_pkg::EV_IGNORED;
      out_valid_nxt = 1'b1;
      case (in_key_code) inside
        [kfc_pkg::KEY_0:kfc_pkg::KEY_9]: begin
          if (!second_r) begin
            if (first_cnt_r < CW'(MAX_DIGITS)) begin
              first_op_nxt  = cur_times10;
              first_cnt_nxt = first_cnt_r + CW'(1);
              out_kind_nxt  = kfc_pkg::EV_DIGIT;
            end
          end else begin
            if (second_cnt_r < CW'(MAX_DIGITS)) begin
              second_op_nxt  = cur_times10;
              second_cnt_nxt = second_cnt_r + CW'(1);
              out_kind_nxt   = kfc_pkg::EV_DIGIT;
            end
          end
        end
        kfc_pkg::KEY_PLUS, kfc_pkg::KEY_MINUS, kfc_pkg::KEY_TIMES, kfc_pkg::KEY_SLASH: begin
          // a second operator is dropped
          if (!second_r) begin
            second_nxt   = 1'b1;
            out_kind_nxt = kfc_pkg::EV_OPERATOR;
            case (in_key_code)
              kfc_pkg::KEY_PLUS:  op_nxt = kfc_pkg::OP_ADD;
              kfc_pkg::KEY_MINUS: op_nxt = kfc_pkg::OP_SUB;
              kfc_pkg::KEY_TIMES: op_nxt = kfc_pkg::OP_MUL;
              default:            op_nxt = kfc_pkg::OP_DIV;
            endcase
          end
        end
        kfc_pkg::KEY_EQ: begin
          out_kind_nxt = kfc_pkg::EV_RESULT;
          // with an operator held the transaction is answered when the unit finishes
          if (op_r != kfc_pkg::OP_NONE) begin
            alu_req.start = 1'b1;
            out_valid_nxt = 1'b0;
          end
          first_op_nxt   = '0;
          second_op_nxt  = '0;
          first_cnt_nxt  = '0;
          second_cnt_nxt = '0;
          second_nxt     = 1'b0;
        end
        kfc_pkg::KEY_CLR: begin
          out_kind_nxt   = kfc_pkg::EV_CLEARED;
          first_op_nxt   = '0;
          second_op_nxt  = '0;
          first_cnt_nxt  = '0;
          second_cnt_nxt = '0;
          second_nxt     = 1'b0;
        end
        default: begin
          // no key or unknown key leaves everything alone
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_op_r    <= '0;
      second_op_r   <= '0;
      first_cnt_r   <= '0;
      second_cnt_r  <= '0;
      op_r          <= kfc_pkg::OP_NONE;
      second_r      <= 1'b0;
      last_result_r <= '0;
      out_valid_r   <= 1'b0;
      out_kind_r    <= kfc_pkg::EV_IGNORED;
    end else begin
      first_op_r    <= first_op_nxt;
      second_op_r   <= second_op_nxt;
      first_cnt_r   <= first_cnt_nxt;
      second_cnt_r  <= second_cnt_nxt;
      op_r          <= op_nxt;
      second_r      <= second_nxt;
      last_result_r <= last_result_nxt;
      out_valid_r   <= out_valid_nxt;
      out_kind_r    <= out_kind_nxt;
    end
  end

  kfc_serial_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .x_val  (alu_x),
    .y_val  (second_op_r),
    .sts    (alu_sts),
    .result (alu_result)
  );

  // the result register only moves while no transaction is on offer, so it drives the port
  assign out_valid             = out_valid_r;
  assign out_event_kind        = out_kind_r;
  assign out_result_hundredths = last_result_r;

  // a key that needs no arithmetic is answered on the next cycle
  `ASSERT_NEXT(a_quick_answer, clk, rst_n, in_accept && !alu_req.start, out_valid_r, "quick key not answered")
  // no key is taken while the unit runs
  `ASSERT_IMPLIES(a_busy_stalls, clk, rst_n, alu_sts.busy, in_stall, "key taken while unit busy")
  // the unit never finishes over a pending transaction
  `ASSERT_IMPLIES(a_done_slot_free, clk, rst_n, alu_sts.done, !out_valid_r, "result overwrites pending output")
  // starting the unit leaves the output slot empty until it finishes
  `ASSERT_NEXT(a_start_holds_out, clk, rst_n, alu_req.start, !out_valid_r && alu_sts.busy, "output raised before result")

endmodule
